>>> src/lpl_pkg.sv
// ----------------------------------------------------------------------------
// lpl_pkg: shared types and constants of the lookahead peak limiter
// Controller states and the command/status structs between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned GAIN_W   = 25;
    localparam int unsigned CEIL_W   = 23;
    localparam int unsigned COEFF_W  = 16;
    localparam int unsigned LEN_W    = 8;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 25'd16777216;

    localparam logic [1:0] REG_CEILING = 2'd0;
    localparam logic [1:0] REG_ATTACK  = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_LOOK    = 2'd3;

    localparam logic [CEIL_W-1:0]  RST_CEILING = 23'd8388607;
    localparam logic [COEFF_W-1:0] RST_ATTACK  = 16'd0;
    localparam logic [COEFF_W-1:0] RST_RELEASE = 16'd65000;
    localparam logic [LEN_W-1:0]   RST_LOOK    = 8'd240;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIV,
        ST_SMOOTH,
        ST_SCALE,
        ST_CLAMP,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_start;   // restart the clearing sweep position
        logic clr_step;    // clear one ring entry and advance
        logic take_in;     // capture the input frame, write stores
        logic scan_start;
        logic scan_step;   // fold one ring entry into the maximum
        logic div_start;
        logic div_step;
        logic smooth;
        logic scale;
        logic clamp;
        logic out_load;
        logic advance;     // move write position
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic scan_last;
        logic div_done;
    } t_status;

endpackage

>>> src/lpl_ctrl.sv
// ----------------------------------------------------------------------------
// lpl_ctrl: controller of the lookahead peak limiter
// Sequences clearing, store write, ring scan, serial divide, smoothing and
// output scaling for one item at a time.
// ----------------------------------------------------------------------------
module lpl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_clear_req,
    input  lpl_pkg::t_status  i_status,
    output lpl_pkg::t_cmd     o_cmd
);

    lpl_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpl_pkg::ST_CLEAR:    if (i_status.clr_done) n_state = lpl_pkg::ST_IDLE;
            lpl_pkg::ST_IDLE: begin
                if (i_clear_req)     n_state = lpl_pkg::ST_CLEAR;
                else if (i_in_valid) n_state = lpl_pkg::ST_WRITE;
            end
            lpl_pkg::ST_WRITE:    n_state = lpl_pkg::ST_SCAN;
            lpl_pkg::ST_SCAN:     if (i_status.scan_last) n_state = lpl_pkg::ST_SCAN_END;
            lpl_pkg::ST_SCAN_END: n_state = lpl_pkg::ST_DIV;
            lpl_pkg::ST_DIV:      if (i_status.div_done) n_state = lpl_pkg::ST_SMOOTH;
            lpl_pkg::ST_SMOOTH:   n_state = lpl_pkg::ST_SCALE;
            lpl_pkg::ST_SCALE:    n_state = lpl_pkg::ST_CLAMP;
            lpl_pkg::ST_CLAMP:    n_state = lpl_pkg::ST_OUT;
            lpl_pkg::ST_OUT:      if (!r_out_valid || i_out_ready) n_state = lpl_pkg::ST_IDLE;
            default:              n_state = lpl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            lpl_pkg::ST_CLEAR:    o_cmd.clr_step = 1'b1;
            lpl_pkg::ST_IDLE: begin
                o_cmd.clr_start = i_clear_req;
                o_cmd.take_in   = !i_clear_req && i_in_valid;
            end
            lpl_pkg::ST_WRITE:    o_cmd.scan_start = 1'b1;
            lpl_pkg::ST_SCAN:     o_cmd.scan_step = 1'b1;
            lpl_pkg::ST_SCAN_END: o_cmd.div_start = 1'b1;
            lpl_pkg::ST_DIV:      o_cmd.div_step = 1'b1;
            lpl_pkg::ST_SMOOTH:   o_cmd.smooth = 1'b1;
            lpl_pkg::ST_SCALE:    o_cmd.scale = 1'b1;
            lpl_pkg::ST_CLAMP:    o_cmd.clamp = 1'b1;
            lpl_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.advance  = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpl_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == lpl_pkg::ST_IDLE) && !i_clear_req;
    assign o_out_valid = r_out_valid;

    // a result is only loaded where the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");
    // input never taken while clearing
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpl_pkg::ST_CLEAR) |-> !o_in_ready)
        else $error("input accepted during clear");
    // the divide starts right after the scan finishes
    a_div_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpl_pkg::ST_SCAN_END) |=> (r_state == lpl_pkg::ST_DIV))
        else $error("divide not started after scan");

endmodule

>>> src/lpl_dpath.sv
// ----------------------------------------------------------------------------
// lpl_dpath: datapath of the lookahead peak limiter
// Peak and delay rings in memories, serial maximum scan, restoring divider,
// gain smoother and the per-channel scale and clamp.
// ----------------------------------------------------------------------------
module lpl_dpath #(
    parameter int unsigned MAX_LOOKAHEAD = 255,
    parameter int unsigned CHANNELS      = 2
) (
    input  logic                                i_clk,
    input  lpl_pkg::t_cmd                       i_cmd,
    output lpl_pkg::t_status                    o_status,
    input  logic [lpl_pkg::CEIL_W-1:0]          i_ceiling,
    input  logic [lpl_pkg::COEFF_W-1:0]         i_attack,
    input  logic [lpl_pkg::COEFF_W-1:0]         i_release,
    input  logic [lpl_pkg::LEN_W-1:0]           i_look,
    input  logic                                i_rst_n,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0] i_sample_ch1,
    output logic signed [lpl_pkg::SAMPLE_W-1:0] o_out_ch0,
    output logic signed [lpl_pkg::SAMPLE_W-1:0] o_out_ch1,
    output logic [lpl_pkg::GAIN_W-1:0]          o_gain_now
);

    localparam int unsigned RING  = MAX_LOOKAHEAD + 1;
    localparam int unsigned AW    = $clog2(RING);
    localparam int unsigned LANES = (CHANNELS < 2) ? CHANNELS : 2;
    localparam int unsigned SW    = lpl_pkg::SAMPLE_W;
    localparam int unsigned GW    = lpl_pkg::GAIN_W;
    localparam int unsigned NW    = lpl_pkg::CEIL_W + 24;

    // ring size: effective lookahead plus one
    logic [AW:0] w_look_eff;
    logic [AW:0] w_size;
    always_comb begin
        if (i_look == '0)
            w_look_eff = (AW+1)'(1);
        else if (32'(i_look) > MAX_LOOKAHEAD)
            w_look_eff = (AW+1)'(MAX_LOOKAHEAD);
        else
            w_look_eff = (AW+1)'(i_look);
        w_size = w_look_eff + (AW+1)'(1);
    end

    // memories: peak ring and one delay ring per channel
    logic [SW-1:0]        r_peak_mem [RING];
    logic signed [SW-1:0] r_dly0_mem [RING];
    logic signed [SW-1:0] r_dly1_mem [RING];

    logic [AW-1:0] r_pos, r_addr, r_clr;
    logic [SW-1:0] r_pk_rd, r_max, w_max_nx;
    logic signed [SW-1:0] r_d0, r_d1;
    logic [SW-1:0] w_m0, w_m1, w_frame_pk;
    logic r_clr_done;
    logic [AW:0] r_scan_cnt;
    logic r_scan_vld;

    // position wrap of the stored position against current ring size
    logic [AW-1:0] w_pos, w_rd;
    always_comb begin
        w_pos = ({1'b0, r_pos} >= w_size) ? '0 : r_pos;
        if ({1'b0, w_pos} + (AW+1)'(1) >= w_size) w_rd = '0;
        else w_rd = w_pos + AW'(1);
    end

    // frame peak magnitude
    always_comb begin
        w_m0 = i_sample_ch0[SW-1] ? SW'(-i_sample_ch0) : SW'(i_sample_ch0);
        w_m1 = (LANES > 1) ? (i_sample_ch1[SW-1] ? SW'(-i_sample_ch1)
                                                 : SW'(i_sample_ch1)) : '0;
        w_frame_pk = (w_m1 > w_m0) ? w_m1 : w_m0;
    end

    // running maximum including the entry read last cycle
    assign w_max_nx = (r_scan_vld && r_pk_rd > r_max) ? r_pk_rd : r_max;

    // memory writes and reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_peak_mem[r_clr] <= '0;
            r_dly0_mem[r_clr] <= '0;
            r_dly1_mem[r_clr] <= '0;
        end else if (i_cmd.take_in) begin
            r_peak_mem[w_pos] <= w_frame_pk;
            r_dly0_mem[w_pos] <= i_sample_ch0;
            r_dly1_mem[w_pos] <= (LANES > 1) ? i_sample_ch1 : '0;
        end
        r_pk_rd <= r_peak_mem[r_addr];
        r_d0    <= r_dly0_mem[w_rd];
        r_d1    <= r_dly1_mem[w_rd];
    end

    // clear sweep, scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_step;
            if (i_cmd.clr_start) begin
                r_clr <= '0;
                r_clr_done <= 1'b0;
                r_pos <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
                r_clr_done <= (r_clr == AW'(RING - 2));
            end
            if (i_cmd.advance) r_pos <= w_rd;
        end
        if (i_cmd.scan_start) begin
            r_addr     <= '0;
            r_scan_cnt <= '0;
            r_max      <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_addr     <= r_addr + AW'(1);
                r_scan_cnt <= r_scan_cnt + (AW+1)'(1);
            end
            r_max <= w_max_nx;
        end
    end

    assign o_status.clr_done  = r_clr_done;
    assign o_status.scan_last = (r_scan_cnt == w_size - (AW+1)'(1));

    // restoring divider: ceiling << 24 / max, one quotient bit per cycle
    logic [NW-1:0] r_num;
    logic [SW:0]   r_rem;
    logic [GW-1:0] r_quo;
    logic [5:0]    r_div_cnt;
    logic          r_need_div;
    logic [SW:0]   w_trial;
    logic [SW+1:0] w_shift;
    always_comb begin
        w_shift = {r_rem, r_num[NW-1]};
        w_trial = w_shift[SW:0] - {1'b0, r_max};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num      <= {i_ceiling, 24'd0};
            r_rem      <= '0;
            r_quo      <= '0;
            r_div_cnt  <= 6'(NW);
            r_need_div <= (w_max_nx > SW'(i_ceiling));
        end else if (i_cmd.div_step && r_div_cnt != '0) begin
            r_num     <= {r_num[NW-2:0], 1'b0};
            r_div_cnt <= r_div_cnt - 6'd1;
            if (w_shift >= {2'b00, r_max}) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[GW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[SW:0];
                r_quo <= {r_quo[GW-2:0], 1'b0};
            end
        end
    end
    assign o_status.div_done = (r_div_cnt == 6'd1) || !r_need_div;

    // smoother: one multiply, then clamp to unity
    logic [GW-1:0] r_gain, w_target, w_d;
    logic [GW+lpl_pkg::COEFF_W-1:0] w_prod;
    logic          w_fall;
    logic [GW:0]   w_new;
    always_comb begin
        w_target = r_need_div ? r_quo : lpl_pkg::UNITY_GAIN;
        w_fall   = w_target < r_gain;
        w_d      = w_fall ? (r_gain - w_target) : (w_target - r_gain);
        w_prod   = (w_fall ? i_attack : i_release) * w_d;
        w_new    = w_fall ? ({1'b0, w_target} + (GW+1)'(w_prod >> 16))
                          : ({1'b0, w_target} - (GW+1)'(w_prod >> 16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gain <= lpl_pkg::UNITY_GAIN;
        else if (i_cmd.smooth)
            r_gain <= (w_new > (GW+1)'(lpl_pkg::UNITY_GAIN)) ? lpl_pkg::UNITY_GAIN
                                                              : w_new[GW-1:0];
    end

    // scale: magnitude times gain, registered
    logic [SW-1:0] w_mag0, w_mag1;
    logic [SW+GW-1:0] r_sc0, r_sc1;
    logic r_neg0, r_neg1;
    assign w_mag0 = r_d0[SW-1] ? SW'(-r_d0) : SW'(r_d0);
    assign w_mag1 = r_d1[SW-1] ? SW'(-r_d1) : SW'(r_d1);
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_sc0  <= (SW+GW)'(w_mag0) * (SW+GW)'(r_gain);
            r_sc1  <= (SW+GW)'(w_mag1) * (SW+GW)'(r_gain);
            r_neg0 <= r_d0[SW-1];
            r_neg1 <= r_d1[SW-1];
        end
    end

    // clamp to the ceiling, apply sign
    logic [SW:0] w_s0, w_s1;
    logic signed [SW-1:0] r_y0, r_y1, w_y0, w_y1;
    always_comb begin
        w_s0 = (SW+1)'(r_sc0 >> 24);
        w_s1 = (SW+1)'(r_sc1 >> 24);
        if (w_s0 > (SW+1)'(i_ceiling)) w_s0 = (SW+1)'(i_ceiling);
        if (w_s1 > (SW+1)'(i_ceiling)) w_s1 = (SW+1)'(i_ceiling);
        w_y0 = r_neg0 ? -SW'(w_s0) : SW'(w_s0);
        w_y1 = r_neg1 ? -SW'(w_s1) : SW'(w_s1);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_y0 <= w_y0;
            r_y1 <= (LANES > 1) ? w_y1 : '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_ch0  <= r_y0;
            o_out_ch1  <= r_y1;
            o_gain_now <= r_gain;
        end
    end

    // the gain never exceeds unity
    a_gain_le_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= lpl_pkg::UNITY_GAIN)
        else $error("gain above unity");
    // positions stay inside the ring
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < RING)
        else $error("write position out of range");
    // channel 0 output at most the ceiling after load, unless the ceiling just changed
    a_out_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.out_load) |-> (o_out_ch0 <= $signed({2'b0, i_ceiling}) ||
                                   $past(i_ceiling) != i_ceiling))
        else $error("output above ceiling");

endmodule

>>> src/lookahead_peak_limiter.sv
// ----------------------------------------------------------------------------
// lookahead_peak_limiter: stereo lookahead peak limiter
// Delays each channel by the lookahead and scales it by a smoothed gain
// chosen from the ring peak so that the output stays under the ceiling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_in_valid/o_in_ready): one frame of Q1.23 samples.
//   Output channel (o_out_valid/i_out_ready): delayed, scaled samples and the
//   gain applied, Q1.24. One result per item, in order.
//   Config channel (i_cfg_valid/o_cfg_ready, index, data): write while idle.
//   Writing the lookahead length clears both rings and the write position.
// Sequence:
//   After an item is accepted, the controller passes through a write state,
//   the maximum scan over the peak ring entries, one by one over the single
//   memory read port, a hand-over state and the bit-serial divider (which
//   does no divide when the peak is within the ceiling), then smoothing,
//   scaling, clamping and the output load. It then returns to idle to take
//   the next item; a new item is not taken before the last one is loaded.
// Reset and stalls:
//   After reset a clearing sweep zeroes all MAX_LOOKAHEAD + 1 ring entries
//   while no item is accepted. The result sits in an output register; during
//   a stall the next item is still taken and computed, then waits for the
//   register to free while the input is held off.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter #(
    parameter int unsigned MAX_LOOKAHEAD = 255,
    parameter int unsigned CHANNELS      = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0] i_sample_ch1,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lpl_pkg::SAMPLE_W-1:0] o_out_ch0,
    output logic signed [lpl_pkg::SAMPLE_W-1:0] o_out_ch1,
    output logic [lpl_pkg::GAIN_W-1:0]          o_gain_now,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [lpl_pkg::CEIL_W-1:0]          i_cfg_data
);

    logic [lpl_pkg::CEIL_W-1:0]  r_ceiling;
    logic [lpl_pkg::COEFF_W-1:0] r_attack, r_release;
    logic [lpl_pkg::LEN_W-1:0]   r_look;
    logic                        r_clear_req;
    lpl_pkg::t_cmd               w_cmd;
    lpl_pkg::t_status            w_status;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling   <= lpl_pkg::RST_CEILING;
            r_attack    <= lpl_pkg::RST_ATTACK;
            r_release   <= lpl_pkg::RST_RELEASE;
            r_look      <= lpl_pkg::RST_LOOK;
            r_clear_req <= 1'b0;
        end else begin
            if (w_cmd.clr_start) r_clear_req <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lpl_pkg::REG_CEILING: r_ceiling <= i_cfg_data;
                    lpl_pkg::REG_ATTACK:  r_attack  <= i_cfg_data[lpl_pkg::COEFF_W-1:0];
                    lpl_pkg::REG_RELEASE: r_release <= i_cfg_data[lpl_pkg::COEFF_W-1:0];
                    lpl_pkg::REG_LOOK: begin
                        r_look      <= i_cfg_data[lpl_pkg::LEN_W-1:0];
                        r_clear_req <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    lpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_clear_req (r_clear_req),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lpl_dpath #(
        .MAX_LOOKAHEAD (MAX_LOOKAHEAD),
        .CHANNELS      (CHANNELS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_ceiling    (r_ceiling),
        .i_attack     (r_attack),
        .i_release    (r_release),
        .i_look       (r_look),
        .i_rst_n      (i_rst_n),
        .i_sample_ch0 (i_sample_ch0),
        .i_sample_ch1 (i_sample_ch1),
        .o_out_ch0    (o_out_ch0),
        .o_out_ch1    (o_out_ch1),
        .o_gain_now   (o_gain_now)
    );

endmodule
